[hw/rtl/ptsa_pkg.sv]
// ----------------------------------------------------------------------------
// Periodic timer slot array - shared types and codes
// Word layouts, command and result codes and slot record used by the ring.
// ----------------------------------------------------------------------------
package ptsa_pkg;

   localparam int TIME_W = 32;
   localparam int STEP_W = 8;
   localparam logic [STEP_W-1:0] STEP_RESET = 8'd19;

   // command codes
   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_ADD    = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;

   // result kinds
   localparam logic [2:0] KIND_ADDED   = 3'd0;
   localparam logic [2:0] KIND_FULL    = 3'd1;
   localparam logic [2:0] KIND_REMOVED = 3'd2;
   localparam logic [2:0] KIND_FIRED   = 3'd3;
   localparam logic [2:0] KIND_TICK    = 3'd4;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [30:0] delay;
      logic [2:0]  timer_id;
   } ptsa_req_type;

   typedef struct packed {
      logic [2:0]        kind;
      logic [2:0]        timer_id_res;
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] timestamp;
      logic              last;
   } ptsa_rsp_type;

   // contents of one timer slot
   typedef struct packed {
      logic              enabled;
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] deadline;
      logic              dl_epoch;
   } ptsa_slot_type;

endpackage

[hw/rtl/ptsa_cell.sv]
// ----------------------------------------------------------------------------
// Periodic timer slot array - slot cell
// Holds one timer slot; takes its neighbour's slot when the ring shifts.
// ----------------------------------------------------------------------------
module ptsa_cell
   import ptsa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          shift,
   input  ptsa_slot_type slot_in,
   output ptsa_slot_type slot_out
);

   logic              enabled_ff;
   logic              enabled_in;
   logic [TIME_W-1:0] period_ff;
   logic [TIME_W-1:0] period_in;
   logic [TIME_W-1:0] deadline_ff;
   logic [TIME_W-1:0] deadline_in;
   logic              dl_epoch_ff;
   logic              dl_epoch_in;

   always_comb begin
      enabled_in  = enabled_ff;
      period_in   = period_ff;
      deadline_in = deadline_ff;
      dl_epoch_in = dl_epoch_ff;
      if (shift) begin
         enabled_in  = slot_in.enabled;
         period_in   = slot_in.period;
         deadline_in = slot_in.deadline;
         dl_epoch_in = slot_in.dl_epoch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
      end else begin
         enabled_ff <= enabled_in;
      end
   end

   // slot payload: only meaningful once the slot has been claimed
   always_ff @(posedge clock) begin
      period_ff   <= period_in;
      deadline_ff <= deadline_in;
      dl_epoch_ff <= dl_epoch_in;
   end

   assign slot_out.enabled  = enabled_ff;
   assign slot_out.period   = period_ff;
   assign slot_out.deadline = deadline_ff;
   assign slot_out.dl_epoch = dl_epoch_ff;

endmodule

[hw/rtl/periodic_timer_slot_array_core.sv]
// ----------------------------------------------------------------------------
// Periodic timer slot array - top level
// Coarse time counter with epoch bit and a ring of periodic timer slots.
// ----------------------------------------------------------------------------
// The block keeps a 32-bit time counter plus an epoch bit and TIMER_SLOTS
// timer slots held in a ring of cells. Each accepted word is one of: tick
// (advance time by csr tick_step, wrapping to zero and flipping the epoch on
// overflow, then fire every due slot in index order followed by a tick-done
// word), add (claim the lowest free slot, period = delay + delay/4, answer
// added or table full) or remove (free a slot by index). Command code three
// is swallowed with no answer. Every other command walks the ring once: the
// slot in cell 0 is examined and updated by the head logic and written back
// at the tail while the ring shifts by one, so slot k sits at the head on
// walk step k. An item passes through accept, one walk step per slot and one
// closing step; the walk and the closing step pause while the result
// register is full and not being taken. A new word is taken as soon as the
// closing step has been done, even while its last result is still waiting
// in the output. tick_step may be written at any idle time and resets to 19.
// ----------------------------------------------------------------------------
module periodic_timer_slot_array_core
   import ptsa_pkg::*;
#(
   parameter int TIMER_SLOTS = 5
)(
   input  logic              clock,
   input  logic              reset,
   // command words
   input  logic              req_valid,
   output logic              req_stall,
   input  ptsa_req_type      req_word,
   // result words
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ptsa_rsp_type      rsp_word,
   // tick step register
   input  logic              csr_wr_en,
   input  logic [STEP_W-1:0] csr_wr_data
);

   // walk counter: narrowest index that covers all slots
   localparam int CNT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(TIMER_SLOTS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

   state_type         state_ff,    state_in;
   logic [CNT_W-1:0]  walk_idx_ff, walk_idx_in;
   logic [1:0]        cmd_ff,      cmd_in;
   logic [2:0]        id_ff,       id_in;
   logic [TIME_W-1:0] add_per_ff,  add_per_in;
   logic              found_ff,    found_in;
   logic [TIME_W-1:0] time_ff,     time_in;
   logic              epoch_ff,    epoch_in;
   logic [STEP_W-1:0] step_ff,     step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   ptsa_rsp_type      rsp_word_ff,  rsp_word_in;

   // ring of slot cells
   ptsa_slot_type cell_out [TIMER_SLOTS];
   ptsa_slot_type head;
   ptsa_slot_type head_new;
   logic          ring_shift;

   genvar gi;
   generate
      for (gi = 0; gi < TIMER_SLOTS; gi++) begin : g_cell
         ptsa_slot_type cell_in;
         if (gi == TIMER_SLOTS - 1) begin : g_tail
            assign cell_in = head_new;
         end else begin : g_mid
            assign cell_in = cell_out[gi+1];
         end
         ptsa_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift    (ring_shift),
            .slot_in  (cell_in),
            .slot_out (cell_out[gi])
         );
      end
   endgenerate

   assign head = cell_out[0];

   // time + step, carry means wrap to zero
   logic [TIME_W:0] tick_sum;
   assign tick_sum = {1'b0, time_ff} + {{(TIME_W+1-STEP_W){1'b0}}, step_ff};

   // shared reload adder: time + period of the head slot or of the new timer
   logic [TIME_W-1:0] reload_per;
   logic [TIME_W:0]   reload_sum;
   logic              reload_epoch;
   assign reload_per   = (cmd_ff == CMD_ADD) ? add_per_ff : head.period;
   assign reload_sum   = {1'b0, time_ff} + {1'b0, reload_per};
   assign reload_epoch = reload_sum[TIME_W] ? ~epoch_ff : epoch_ff;

   logic head_due;
   assign head_due = head.enabled && (head.dl_epoch == epoch_ff) &&
                     (time_ff >= head.deadline);

   logic out_free;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      walk_idx_in  = walk_idx_ff;
      cmd_in       = cmd_ff;
      id_in        = id_ff;
      add_per_in   = add_per_ff;
      found_in     = found_ff;
      time_in      = time_ff;
      epoch_in     = epoch_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      ring_shift   = 1'b0;
      head_new     = head;

      if (csr_wr_en) begin
         step_in = csr_wr_data;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in      = req_word.cmd;
               id_in       = req_word.timer_id;
               add_per_in  = {1'b0, req_word.delay} + {3'b000, req_word.delay[30:2]};
               found_in    = 1'b0;
               walk_idx_in = '0;
               case (req_word.cmd)
                  CMD_TICK: begin
                     if (tick_sum[TIME_W]) begin
                        time_in  = '0;
                        epoch_in = ~epoch_ff;
                     end else begin
                        time_in = tick_sum[TIME_W-1:0];
                     end
                     state_in = ST_WALK;
                  end
                  CMD_ADD: begin
                     state_in = ST_WALK;
                  end
                  CMD_REMOVE: begin
                     state_in = ST_WALK;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_WALK: begin
            if (out_free) begin
               ring_shift = 1'b1;
               case (cmd_ff)
                  CMD_TICK: begin
                     if (head_due) begin
                        head_new.deadline = reload_sum[TIME_W-1:0];
                        head_new.dl_epoch = reload_epoch;
                        rsp_valid_in = 1'b1;
                        rsp_word_in.kind         = KIND_FIRED;
                        rsp_word_in.timer_id_res = 3'(walk_idx_ff);
                        rsp_word_in.period       = head.period;
                        rsp_word_in.timestamp    = time_ff;
                        rsp_word_in.last         = 1'b0;
                     end
                  end
                  CMD_ADD: begin
                     if (!found_ff && !head.enabled) begin
                        head_new.enabled  = 1'b1;
                        head_new.period   = add_per_ff;
                        head_new.deadline = reload_sum[TIME_W-1:0];
                        head_new.dl_epoch = reload_epoch;
                        found_in = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_word_in.kind         = KIND_ADDED;
                        rsp_word_in.timer_id_res = 3'(walk_idx_ff);
                        rsp_word_in.period       = add_per_ff;
                        rsp_word_in.timestamp    = time_ff;
                        rsp_word_in.last         = 1'b1;
                     end
                  end
                  CMD_REMOVE: begin
                     if (32'(id_ff) == 32'(walk_idx_ff)) begin
                        head_new.enabled = 1'b0;
                     end
                  end
                  default: begin
                     head_new = head;
                  end
               endcase
               if (walk_idx_ff == LAST_IDX) begin
                  state_in = ST_FINISH;
               end else begin
                  walk_idx_in = walk_idx_ff + CNT_W'(1);
               end
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
               rsp_word_in.timestamp = time_ff;
               rsp_word_in.period    = '0;
               rsp_word_in.last      = 1'b1;
               case (cmd_ff)
                  CMD_TICK: begin
                     rsp_valid_in = 1'b1;
                     rsp_word_in.kind         = KIND_TICK;
                     rsp_word_in.timer_id_res = '0;
                  end
                  CMD_ADD: begin
                     // a claimed slot already answered during the walk
                     if (!found_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_word_in.kind         = KIND_FULL;
                        rsp_word_in.timer_id_res = '0;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_word_in.kind         = KIND_REMOVED;
                     rsp_word_in.timer_id_res = id_ff;
                  end
               endcase
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         walk_idx_ff  <= '0;
         found_ff     <= 1'b0;
         time_ff      <= '0;
         epoch_ff     <= 1'b0;
         step_ff      <= STEP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         walk_idx_ff  <= walk_idx_in;
         found_ff     <= found_in;
         time_ff      <= time_in;
         epoch_ff     <= epoch_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // command and result payload
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      id_ff       <= id_in;
      add_per_ff  <= add_per_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
